>>> sv/pwm_audio_sample_playout_macros.svh
// ----------------------------------------------------------------------------
// PWM audio playout assertion macros
// Shared shorthand for the concurrent checks of the playout engine.
// ----------------------------------------------------------------------------
`ifndef PWM_AUDIO_SAMPLE_PLAYOUT_MACROS_SVH
`define PWM_AUDIO_SAMPLE_PLAYOUT_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define PWMAP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define PWMAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pwmap_pkg.sv
// ----------------------------------------------------------------------------
// PWM audio playout package
// Sizes, register codes and the volume attenuation shared by the design.
// ----------------------------------------------------------------------------
package pwmap_pkg;

   localparam int FIFO_DEPTH    = 512;
   localparam int REFILL_MARGIN = 32;
   localparam int ADDR_W        = $clog2(FIFO_DEPTH);
   localparam int COUNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int SAMPLE_W      = 8;
   localparam int TICK_W        = 16;
   localparam int VOLUME_W      = 4;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [COUNT_W-1:0] FILL_FULL      = COUNT_W'(FIFO_DEPTH);
   localparam logic [COUNT_W-1:0] FILL_THRESHOLD = COUNT_W'(FIFO_DEPTH - REFILL_MARGIN);
   localparam logic [ADDR_W-1:0]  ADDR_LAST      = ADDR_W'(FIFO_DEPTH - 1);

   localparam logic [SAMPLE_W-1:0] LEVEL_IDLE     = 8'd127;
   localparam logic [TICK_W-1:0]   TICK_PERIOD_RST = 16'd1999;
   localparam logic [VOLUME_W-1:0] VOLUME_MAX     = 4'd8;

   // input item codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_MODE    = 2'd2;

   typedef enum logic [1:0] {
      RUN_STOP       = 2'd0,
      RUN_PLAY       = 2'd1,
      RUN_PAUSE_HOLD = 2'd2,
      RUN_PAUSE_MUTE = 2'd3
   } run_mode_type;

   // Move a sample toward midpoint 128 by an arithmetic shift of (8-volume)/2.
   function automatic logic [SAMPLE_W-1:0] attenuate(input logic [SAMPLE_W-1:0] sample,
                                                     input logic [VOLUME_W-1:0] volume);
      logic [VOLUME_W-1:0]        vol;
      logic [2:0]                 shift;
      logic signed [SAMPLE_W-1:0] centered;
      logic signed [SAMPLE_W-1:0] shifted;
      vol      = (volume > VOLUME_MAX) ? VOLUME_MAX : volume;
      shift    = 3'((VOLUME_MAX - vol) >> 1);
      centered = $signed({~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]});
      shifted  = centered >>> shift;
      return {~shifted[SAMPLE_W-1], shifted[SAMPLE_W-2:0]};
   endfunction

endpackage

>>> sv/pwmap_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pwmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_ff[write_addr] <= write_data;
      end
      // hold the last read when no read is issued
      if (read_en) begin
         read_data_ff <= store_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> sv/pwm_audio_sample_playout.sv
// ----------------------------------------------------------------------------
// PWM audio sample playout engine
// Ring FIFO of 8-bit PCM bytes drained by a sample-rate timer into a PWM level.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: req_func selects a sample write
//   (req_sample_byte goes into the FIFO) or one timer clock tick.
//   rsp_* returns exactly one result per item, in order: the PWM level held
//   after the item, the slot and underrun flags, whether a write was stored,
//   the FIFO fill level and the refill request.
//   csr_* writes tick_period, volume and run_mode; write only while idle.
// Pipeline: the transfer edge issues the sample store read and loads the
//   read stage; the read stage then loads the output register, which drives
//   rsp_valid, once that register is free.
// Throughput: one item per cycle while req_stall is low; the store read is
//   issued on the same edge that advances the pointers, and a pop only
//   reads an entry written at an earlier edge: no interlock is needed.
// Reset: FIFO empty, timer zero, level 127, tick_period 1999, volume 8,
//   stopped. The store contents are left as they are.
// Stall: a stalled result holds in the output register; the item behind it
//   waits in the read stage and req_stall rises until the result moves.
// ----------------------------------------------------------------------------
module pwm_audio_sample_playout (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [pwmap_pkg::SAMPLE_W-1:0]      req_sample_byte,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pwmap_pkg::SAMPLE_W-1:0]      rsp_pwm_level,
   output logic                                rsp_sample_event,
   output logic                                rsp_underrun,
   output logic                                rsp_write_accepted,
   output logic [pwmap_pkg::COUNT_W-1:0]       rsp_fifo_level,
   output logic                                rsp_want_fill,
   // configuration
   input  logic                                csr_we,
   input  logic [pwmap_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwmap_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [pwmap_pkg::TICK_W-1:0]   tick_period_ff;
   logic [pwmap_pkg::VOLUME_W-1:0] volume_ff;
   pwmap_pkg::run_mode_type        run_mode_ff;

   // FIFO and timer state
   logic [pwmap_pkg::ADDR_W-1:0]   read_ptr_ff,  read_ptr_in;
   logic [pwmap_pkg::ADDR_W-1:0]   write_ptr_ff, write_ptr_in;
   logic [pwmap_pkg::COUNT_W-1:0]  fill_ff,      fill_in;
   logic [pwmap_pkg::TICK_W-1:0]   tick_ff,      tick_in;
   logic [pwmap_pkg::SAMPLE_W-1:0] held_ff,      held_in;

   // read stage
   logic                           s1_valid_ff;
   logic                           s1_event_ff;
   logic                           s1_pop_ff;
   logic                           s1_accepted_ff;
   logic [pwmap_pkg::COUNT_W-1:0]  s1_fill_ff;
   logic                           s1_want_ff;

   // output register
   logic                           out_valid_ff;
   logic [pwmap_pkg::SAMPLE_W-1:0] out_level_ff;
   logic                           out_event_ff;
   logic                           out_underrun_ff;
   logic                           out_accepted_ff;
   logic [pwmap_pkg::COUNT_W-1:0]  out_fill_ff;
   logic                           out_want_ff;

   logic                           accept;
   logic                           is_write;
   logic                           do_write;
   logic                           do_slot;
   logic                           do_pop;
   logic                           out_free;
   logic                           s1_move;
   logic                           muted;
   logic [pwmap_pkg::SAMPLE_W-1:0] ram_rdata;
   logic [pwmap_pkg::SAMPLE_W-1:0] slot_byte;

   // --------------------------------------------------------------------
   // Handshake: the read stage moves when the output register is free;
   // take a new item whenever the read stage is empty or moving.
   // --------------------------------------------------------------------
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // --------------------------------------------------------------------
   // Front stage: decide the item's effect and advance pointers at once,
   // so the next item sees up-to-date counts.
   // --------------------------------------------------------------------
   assign is_write = (req_func == pwmap_pkg::FUNC_WRITE);
   assign do_write = accept && is_write && (fill_ff != pwmap_pkg::FILL_FULL);
   assign do_slot  = accept && !is_write && (run_mode_ff == pwmap_pkg::RUN_PLAY)
                     && (tick_ff >= tick_period_ff);
   assign do_pop   = do_slot && (fill_ff != '0);

   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      fill_in      = fill_ff;
      tick_in      = tick_ff;

      if (do_write) begin
         write_ptr_in = (write_ptr_ff == pwmap_pkg::ADDR_LAST) ? '0
                        : write_ptr_ff + pwmap_pkg::ADDR_W'(1);
         fill_in      = fill_ff + pwmap_pkg::COUNT_W'(1);
      end

      if (do_pop) begin
         read_ptr_in = (read_ptr_ff == pwmap_pkg::ADDR_LAST) ? '0
                       : read_ptr_ff + pwmap_pkg::ADDR_W'(1);
         fill_in     = fill_ff - pwmap_pkg::COUNT_W'(1);
      end

      // timer: clear when stopped, freeze when paused, wrap at the period
      if (accept && !is_write) begin
         case (run_mode_ff)
            pwmap_pkg::RUN_STOP: begin
               tick_in = '0;
            end
            pwmap_pkg::RUN_PLAY: begin
               tick_in = do_slot ? '0 : tick_ff + pwmap_pkg::TICK_W'(1);
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   // Sample store: write at the tail on a stored byte, read the head on a pop.
   // A pop only reads an entry written by an earlier transfer.
   pwmap_ram #(
      .WIDTH (pwmap_pkg::SAMPLE_W),
      .DEPTH (pwmap_pkg::FIFO_DEPTH)
   ) u_store (
      .clock      (clock),
      .write_en   (do_write),
      .write_addr (write_ptr_ff),
      .write_data (req_sample_byte),
      .read_en    (do_pop),
      .read_addr  (read_ptr_ff),
      .read_data  (ram_rdata)
   );

   // --------------------------------------------------------------------
   // Read stage: the popped byte arrives; form the new held level.
   // Stopped and muted modes force the idle level.
   // --------------------------------------------------------------------
   assign muted     = run_mode_ff inside {pwmap_pkg::RUN_STOP, pwmap_pkg::RUN_PAUSE_MUTE};
   assign slot_byte = s1_pop_ff ? ram_rdata : pwmap_pkg::LEVEL_IDLE;

   always_comb begin
      held_in = held_ff;
      if (muted) begin
         held_in = pwmap_pkg::LEVEL_IDLE;
      end else if (s1_event_ff) begin
         held_in = pwmap_pkg::attenuate(slot_byte, volume_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= pwmap_pkg::TICK_PERIOD_RST;
         volume_ff      <= pwmap_pkg::VOLUME_MAX;
         run_mode_ff    <= pwmap_pkg::RUN_STOP;
      end else if (csr_we) begin
         case (csr_index)
            pwmap_pkg::CSR_TICK_PERIOD: begin
               tick_period_ff <= csr_wdata[pwmap_pkg::TICK_W-1:0];
            end
            pwmap_pkg::CSR_VOLUME: begin
               volume_ff <= csr_wdata[pwmap_pkg::VOLUME_W-1:0];
            end
            pwmap_pkg::CSR_RUN_MODE: begin
               run_mode_ff <= pwmap_pkg::run_mode_type'(csr_wdata[1:0]);
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // FIFO, timer and level state
   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff  <= '0;
         write_ptr_ff <= '0;
         fill_ff      <= '0;
         tick_ff      <= '0;
         held_ff      <= pwmap_pkg::LEVEL_IDLE;
      end else begin
         read_ptr_ff  <= read_ptr_in;
         write_ptr_ff <= write_ptr_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         if (s1_move) begin
            held_ff <= held_in;
         end
      end
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_event_ff    <= do_slot;
         s1_pop_ff      <= do_pop;
         s1_accepted_ff <= do_write;
         s1_fill_ff     <= fill_in;
         s1_want_ff     <= (fill_in < pwmap_pkg::FILL_THRESHOLD);
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_level_ff    <= held_in;
         out_event_ff    <= s1_event_ff;
         out_underrun_ff <= s1_event_ff && !s1_pop_ff;
         out_accepted_ff <= s1_accepted_ff;
         out_fill_ff     <= s1_fill_ff;
         out_want_ff     <= s1_want_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pwm_level      = out_level_ff;
   assign rsp_sample_event   = out_event_ff;
   assign rsp_underrun       = out_underrun_ff;
   assign rsp_write_accepted = out_accepted_ff;
   assign rsp_fifo_level     = out_fill_ff;
   assign rsp_want_fill      = out_want_ff;

endmodule

>>> sv/pwmap_chk.sv
// ----------------------------------------------------------------------------
// PWM audio playout checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pwm_audio_sample_playout_macros.svh"

module pwmap_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [pwmap_pkg::SAMPLE_W-1:0]    rsp_pwm_level,
   input logic                              rsp_sample_event,
   input logic                              rsp_underrun,
   input logic                              rsp_write_accepted,
   input logic [pwmap_pkg::COUNT_W-1:0]     rsp_fifo_level,
   input logic                              rsp_want_fill
);

   // an underrun is a played slot that found the FIFO empty
   `PWMAP_ASSERT_NOW(a_underrun_empty,
      rsp_valid && rsp_underrun,
      rsp_sample_event && (rsp_fifo_level == '0),
      "underrun without an empty played slot")

   // an item is either a write or a tick, never both
   `PWMAP_ASSERT_NOW(a_write_or_slot,
      rsp_valid,
      !(rsp_write_accepted && rsp_sample_event),
      "write and sample slot in one result")

   // refill request follows the fill level
   `PWMAP_ASSERT_NOW(a_want_fill,
      rsp_valid,
      rsp_want_fill == (rsp_fifo_level < pwmap_pkg::FILL_THRESHOLD),
      "refill request disagrees with fill level")

   // fill level never exceeds the store
   `PWMAP_ASSERT_NOW(a_fill_bound,
      rsp_valid,
      rsp_fifo_level <= pwmap_pkg::FILL_FULL,
      "fill level above FIFO depth")

   // a stalled result holds
   `PWMAP_ASSERT_NEXT(a_stall_hold,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pwm_level) && $stable(rsp_fifo_level),
      "stalled result changed")

endmodule

bind pwm_audio_sample_playout pwmap_chk u_pwmap_chk (.*);

>>> dv/pwm_audio_sample_playout_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM audio playout checker
// Tracks register writes and item transfers, predicts one result per item
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module pwm_audio_sample_playout_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_func,
   input  logic [pwmap_pkg::SAMPLE_W-1:0]      req_sample_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pwmap_pkg::SAMPLE_W-1:0]      rsp_pwm_level,
   input  logic                                rsp_sample_event,
   input  logic                                rsp_underrun,
   input  logic                                rsp_write_accepted,
   input  logic [pwmap_pkg::COUNT_W-1:0]       rsp_fifo_level,
   input  logic                                rsp_want_fill,
   input  logic                                csr_we,
   input  logic [pwmap_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwmap_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);

   typedef struct packed {
      logic [pwmap_pkg::SAMPLE_W-1:0] level;
      logic                           slot;
      logic                           empty_slot;
      logic                           stored;
      logic [pwmap_pkg::COUNT_W-1:0]  fill;
      logic                           refill;
   } playout_result_type;

   // predicted engine state
   logic [pwmap_pkg::SAMPLE_W-1:0] sample_mem [pwmap_pkg::FIFO_DEPTH];
   logic [pwmap_pkg::ADDR_W-1:0]   rd_ptr;
   logic [pwmap_pkg::ADDR_W-1:0]   wr_ptr;
   logic [pwmap_pkg::COUNT_W-1:0]  fill_count;
   logic [pwmap_pkg::TICK_W-1:0]   tick_count;
   logic [pwmap_pkg::SAMPLE_W-1:0] held_level;

   // predicted register contents
   logic [pwmap_pkg::TICK_W-1:0]   period_reg;
   logic [pwmap_pkg::VOLUME_W-1:0] volume_reg;
   pwmap_pkg::run_mode_type        mode_reg;

   playout_result_type  results_due [$];
   int                  failures = 0;
   int                  due_count = 0;

   assign fail_count = failures;
   assign pending    = due_count;

   // Pull a sample toward midpoint 128; volumes above 8 leave it untouched.
   function automatic logic [pwmap_pkg::SAMPLE_W-1:0] scale_toward_mid(
      input logic [pwmap_pkg::SAMPLE_W-1:0] s);
      int shift;
      int centered;
      shift    = (volume_reg >= 4'd8) ? 0 : (8 - int'(volume_reg)) / 2;
      centered = int'(s) - 128;
      centered = centered >>> shift;
      return pwmap_pkg::SAMPLE_W'(centered + 128);
   endfunction

   function automatic playout_result_type advance_playout(
      input logic                           func,
      input logic [pwmap_pkg::SAMPLE_W-1:0] sample_in);
      playout_result_type             r;
      logic [pwmap_pkg::SAMPLE_W-1:0] popped;
      r = '0;
      if (mode_reg == pwmap_pkg::RUN_STOP || mode_reg == pwmap_pkg::RUN_PAUSE_MUTE)
         held_level = pwmap_pkg::LEVEL_IDLE;
      if (func == pwmap_pkg::FUNC_WRITE) begin
         if (fill_count < pwmap_pkg::FILL_FULL) begin
            sample_mem[wr_ptr] = sample_in;
            wr_ptr     = (wr_ptr == pwmap_pkg::ADDR_LAST) ? '0 : wr_ptr + 1'b1;
            fill_count = fill_count + 1'b1;
            r.stored   = 1'b1;
         end
      end else if (mode_reg == pwmap_pkg::RUN_STOP) begin
         tick_count = '0;
      end else if (mode_reg == pwmap_pkg::RUN_PLAY) begin
         if (tick_count >= period_reg) begin
            tick_count = '0;
            r.slot     = 1'b1;
            popped     = pwmap_pkg::LEVEL_IDLE;
            if (fill_count != '0) begin
               popped     = sample_mem[rd_ptr];
               rd_ptr     = (rd_ptr == pwmap_pkg::ADDR_LAST) ? '0 : rd_ptr + 1'b1;
               fill_count = fill_count - 1'b1;
            end else begin
               r.empty_slot = 1'b1;
            end
            held_level = scale_toward_mid(popped);
         end else begin
            tick_count = tick_count + 1'b1;
         end
      end
      r.level  = held_level;
      r.fill   = fill_count;
      r.refill = (fill_count < pwmap_pkg::FILL_THRESHOLD);
      return r;
   endfunction

   always @(posedge clock) begin
      playout_result_type got;
      playout_result_type want;
      if (reset) begin
         rd_ptr     = '0;
         wr_ptr     = '0;
         fill_count = '0;
         tick_count = '0;
         held_level = pwmap_pkg::LEVEL_IDLE;
         period_reg = pwmap_pkg::TICK_PERIOD_RST;
         volume_reg = pwmap_pkg::VOLUME_MAX;
         mode_reg   = pwmap_pkg::RUN_STOP;
         results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pwmap_pkg::CSR_TICK_PERIOD:
                  period_reg = csr_wdata[pwmap_pkg::TICK_W-1:0];
               pwmap_pkg::CSR_VOLUME:
                  volume_reg = csr_wdata[pwmap_pkg::VOLUME_W-1:0];
               pwmap_pkg::CSR_RUN_MODE:
                  mode_reg   = pwmap_pkg::run_mode_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.level      = rsp_pwm_level;
            got.slot       = rsp_sample_event;
            got.empty_slot = rsp_underrun;
            got.stored     = rsp_write_accepted;
            got.fill       = rsp_fifo_level;
            got.refill     = rsp_want_fill;
            if (results_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result transfer with nothing predicted (level %0d fill %0d)",
                           $time, got.level, got.fill);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display({"%0t: result differs (exp/act) level %0d/%0d slot %0b/%0b ",
                               "underrun %0b/%0b stored %0b/%0b fill %0d/%0d refill %0b/%0b"},
                              $time, want.level, got.level, want.slot, got.slot,
                              want.empty_slot, got.empty_slot, want.stored, got.stored,
                              want.fill, got.fill, want.refill, got.refill);
               end
            end
         end
         if (req_valid && !req_stall)
            results_due.push_back(advance_playout(req_func, req_sample_byte));
      end
      due_count = results_due.size();
   end

endmodule

>>> dv/pwm_audio_sample_playout_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM audio playout testbench
// Drives sample writes and timer ticks through every run mode, a range of
// volumes and a spread of tick periods, with random idling and back-pressure on
// both sides; the checker beside the engine predicts and compares each result.
// ----------------------------------------------------------------------------
module pwm_audio_sample_playout_test;

   // Generous ceiling: about a thousand items with their random idling,
   // plus one long receiver hold, fit many times over.
   localparam int RUN_LIMIT  = 400000;
   // Length of the receiver's long hold-off, in cycles.
   localparam int LONG_HOLD  = 300;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_func;
   logic [pwmap_pkg::SAMPLE_W-1:0]    req_sample_byte;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [pwmap_pkg::SAMPLE_W-1:0]    rsp_pwm_level;
   logic                              rsp_sample_event;
   logic                              rsp_underrun;
   logic                              rsp_write_accepted;
   logic [pwmap_pkg::COUNT_W-1:0]     rsp_fifo_level;
   logic                              rsp_want_fill;
   logic                              csr_we;
   logic [pwmap_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pwmap_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int   fail_count;
   int   pending;
   int   cycle_count = 0;

   // Shared knobs: quiet_gaps switches idling off on both sides; bumping
   // holds_asked makes the receiver start one long hold-off.
   logic quiet_gaps;
   int   holds_asked;

   pwm_audio_sample_playout dut (.*);

   pwm_audio_sample_playout_checker playout_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop a hung run: a missing result or a stuck stall lands here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: random stalls, or a long hold-off when one is asked for.
   // The hold is counted here so the sender keeps offering items meanwhile.
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_gaps && ($urandom_range(99) < 20);
         end
      end
   end

   // Offer one item, idling first at random, and hold it until the transfer.
   task automatic put_item(input logic func, input logic [pwmap_pkg::SAMPLE_W-1:0] value);
      @(negedge clock);
      while (!quiet_gaps && $urandom_range(99) < 20) begin
         req_valid       <= 1'b0;
         req_func        <= 1'($urandom_range(1));
         req_sample_byte <= pwmap_pkg::SAMPLE_W'($urandom_range(255));
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_sample_byte <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Pick a write or a tick with the given write share, random byte either way.
   task automatic put_random(input int write_pct);
      put_item(($urandom_range(99) < write_pct) ? pwmap_pkg::FUNC_WRITE : pwmap_pkg::FUNC_TICK,
               pwmap_pkg::SAMPLE_W'($urandom_range(255)));
   endtask

   // Drop valid and wait until every predicted result has been taken.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [pwmap_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pwmap_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int write_pct;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = pwmap_pkg::FUNC_WRITE;
      req_sample_byte = '0;
      csr_we          = 1'b0;
      csr_index       = pwmap_pkg::CSR_TICK_PERIOD;
      csr_wdata       = '0;
      quiet_gaps      = 1'b0;
      holds_asked     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Writes land while stopped; stopped ticks keep the timer at zero.
      put_item(pwmap_pkg::FUNC_WRITE, 8'h00);
      put_item(pwmap_pkg::FUNC_WRITE, 8'hFF);
      put_item(pwmap_pkg::FUNC_WRITE, 8'h80);
      put_item(pwmap_pkg::FUNC_WRITE, 8'h7F);
      put_item(pwmap_pkg::FUNC_WRITE, 8'h01);
      put_item(pwmap_pkg::FUNC_TICK, 8'hFF);
      put_item(pwmap_pkg::FUNC_TICK, 8'h00);

      // Period zero plays on every tick; volume zero gives the deepest shift.
      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'd0);
      write_reg(pwmap_pkg::CSR_VOLUME, 16'd0);
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PLAY));
      repeat (3) put_item(pwmap_pkg::FUNC_TICK, 8'h00);

      // Volume above eight acts as full scale; the third tick underruns.
      settle();
      write_reg(pwmap_pkg::CSR_VOLUME, 16'd15);
      repeat (3) put_item(pwmap_pkg::FUNC_TICK, 8'hA5);

      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'd2);
      put_item(pwmap_pkg::FUNC_WRITE, 8'hC3);
      repeat (3) put_item(pwmap_pkg::FUNC_TICK, 8'h5A);

      // Paused with level held, then paused muted: timer frozen, writes still land.
      settle();
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PAUSE_HOLD));
      put_item(pwmap_pkg::FUNC_TICK, 8'h11);
      put_item(pwmap_pkg::FUNC_WRITE, 8'h3C);
      settle();
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PAUSE_MUTE));
      put_item(pwmap_pkg::FUNC_TICK, 8'h22);
      put_item(pwmap_pkg::FUNC_WRITE, 8'hE1);

      // Count up under the longest period, then lower it below the counter:
      // the next tick must play at once.
      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'hFFFF);
      write_reg(pwmap_pkg::CSR_VOLUME, 16'd8);
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PLAY));
      repeat (40) put_item(pwmap_pkg::FUNC_TICK, pwmap_pkg::SAMPLE_W'($urandom_range(255)));
      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'd5);
      repeat (3) put_item(pwmap_pkg::FUNC_TICK, pwmap_pkg::SAMPLE_W'($urandom_range(255)));

      // Fill to the brim while paused, with the receiver held off at first so
      // the engine backs up and stalls its input; late writes hit a full FIFO.
      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'($urandom_range(6)));
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PAUSE_HOLD));
      quiet_gaps = 1'b1;
      holds_asked++;
      for (int i = 0; i < 540; i++) begin
         if (i == 150)
            quiet_gaps = 1'b0;
         put_random(97);
      end

      // Drain back to back with no idling on either side.
      settle();
      write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'd0);
      write_reg(pwmap_pkg::CSR_VOLUME, 16'($urandom_range(15)));
      write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PLAY));
      quiet_gaps = 1'b1;
      repeat (180) put_random(15);
      quiet_gaps = 1'b0;

      // Short random phases over the whole register space, mostly playing.
      for (int p = 0; p < 8; p++) begin
         settle();
         case ($urandom_range(9))
            0:       write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'd50);
            1:       write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'hFFFF);
            default: write_reg(pwmap_pkg::CSR_TICK_PERIOD, 16'($urandom_range(6)));
         endcase
         write_reg(pwmap_pkg::CSR_VOLUME, 16'($urandom_range(15)));
         if ($urandom_range(99) < 60)
            write_reg(pwmap_pkg::CSR_RUN_MODE, 16'(pwmap_pkg::RUN_PLAY));
         else
            write_reg(pwmap_pkg::CSR_RUN_MODE, 16'($urandom_range(3)));
         write_pct = $urandom_range(20, 80);
         repeat (25) put_random(write_pct);
      end

      // Wait out every result, then the two-stage pipeline once more.
      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/pwmap_pkg.sv
sv/pwmap_ram.sv
sv/pwm_audio_sample_playout.sv
sv/pwmap_chk.sv
dv/pwm_audio_sample_playout_checker.sv
dv/pwm_audio_sample_playout_test.sv
